>>> src/mcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types, constants and MD5 round tables for the mask candidate block.
// ----------------------------------------------------------------------------
package mcm_pkg;

    localparam int CHARSET_DEPTH = 256;
    localparam int CS_AW         = (CHARSET_DEPTH > 1) ? $clog2(CHARSET_DEPTH) : 1;
    localparam int MAX_LEN       = 8;
    localparam int LEN_W         = 4;
    localparam int IDX_W         = 64;

    localparam logic [0:0] OP_LOAD = 1'b0;
    localparam logic [0:0] OP_HASH = 1'b1;

    localparam logic [0:0] REG_CHARSET_SIZE = 1'b0;
    localparam logic [0:0] REG_PW_LENGTH    = 1'b1;

    // Decoded hash job handed from the front part to the back part
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [63:0]      pw;
    } t_job;

    // Round constant of MD5
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    // Rotate amount of MD5 by round group and step within group
    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> src/mcm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcm_front
// Accepts items, writes the charset table and decodes a candidate index into
// password bytes, one restoring-division bit per cycle.
// ----------------------------------------------------------------------------
module mcm_front
    import mcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_opcode,
    input  wire logic [7:0]       i_pos,
    input  wire logic [7:0]       i_char,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic [7:0]       i_radix,
    input  wire logic [LEN_W-1:0] i_len,
    output logic                  o_job_valid,
    input  wire logic             i_job_ready,
    output t_job                  o_job
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]       r_state;
    logic [IDX_W-1:0] r_quo;
    logic [7:0]       r_rem;
    logic [7:0]       r_radix;
    logic [5:0]       r_bit;
    logic [3:0]       r_digit;
    logic [LEN_W-1:0] r_len;
    logic [63:0]      r_pw;
    logic [7:0]       r_rd;
    logic [7:0]       r_mem [CHARSET_DEPTH];

    logic [8:0] w_trial;
    logic [8:0] w_diff;
    logic       w_ge;
    logic [7:0] w_pos_full;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_job_valid = (r_state == ST_PUSH);
    assign o_job.len   = r_len;
    assign o_job.pw    = r_pw;

    // One restoring step: shift in the next dividend bit
    assign w_trial = {r_rem, r_quo[IDX_W-1]};
    assign w_diff  = w_trial - {1'b0, r_radix};
    assign w_ge    = (w_trial >= {1'b0, r_radix});
    assign w_pos_full = i_pos;

    // Charset table: written by load items, read with registered data
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && (i_opcode == OP_LOAD)
            && ({1'b0, w_pos_full} < 9'(CHARSET_DEPTH))) begin
            r_mem[i_pos[CS_AW-1:0]] <= i_char;
        end
        if (r_state == ST_RD) begin
            r_rd <= r_mem[r_rem[CS_AW-1:0]];
        end
    end

    // Sequencer: one digit per 64 division steps, least significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && (i_opcode == OP_HASH)) begin
                        r_radix <= (i_radix == 8'd0) ? 8'd1 : i_radix;
                        r_len   <= (i_len == 4'd0) ? 4'd1 :
                                   (i_len > 4'(MAX_LEN)) ? 4'(MAX_LEN) : i_len;
                        r_digit <= (i_len == 4'd0) ? 4'd0 :
                                   (i_len > 4'(MAX_LEN)) ? 4'(MAX_LEN - 1) : i_len - 4'd1;
                        r_quo   <= i_index;
                        r_rem   <= 8'd0;
                        r_bit   <= 6'd0;
                        r_pw    <= 64'd0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_ge ? w_diff[7:0] : w_trial[7:0];
                    r_quo <= {r_quo[IDX_W-2:0], w_ge};
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'd63) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    r_pw[(7 - r_digit[2:0]) * 8 +: 8] <= r_rd;
                    r_rem <= 8'd0;
                    r_bit <= 6'd0;
                    if (r_digit == 4'd0) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_digit <= r_digit - 4'd1;
                        r_state <= ST_DIV;
                    end
                end
                ST_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/mcm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcm_fifo
// Two-entry job queue between the decoder and the hash core.
// ----------------------------------------------------------------------------
module mcm_fifo
    import mcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_job      i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_data
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

>>> src/mcm_md5.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcm_md5
// Iterative MD5 core: one round per cycle over a single padded block, then
// holds the record in an output register until taken.
// ----------------------------------------------------------------------------
module mcm_md5
    import mcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic [7:0]  o_shard,
    output logic [63:0] o_up,
    output logic [55:0] o_lo,
    output logic [LEN_W-1:0] o_len,
    output logic [63:0] o_pw
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  r_state;
    logic [5:0]  r_i;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_w [16];
    logic [LEN_W-1:0] r_len;
    logic [63:0] r_pw;
    logic [127:0] r_dg;

    logic [31:0] w_f;
    logic [3:0]  w_g;
    logic [31:0] w_sum;
    logic [31:0] w_rot;
    logic [31:0] w_nb;
    logic [4:0]  w_s;
    logic [31:0] w_sa, w_sb, w_sc, w_sd;
    logic [7:0]  w_blk [64];

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    // Build the padded block from the job
    always_comb begin
        for (int j = 0; j < 64; j++) begin
            w_blk[j] = 8'd0;
        end
        for (int j = 0; j < MAX_LEN; j++) begin
            if (4'(j) < i_job.len) begin
                w_blk[j] = i_job.pw[(7 - j) * 8 +: 8];
            end else if (4'(j) == i_job.len) begin
                w_blk[j] = 8'h80;
            end
        end
        if (i_job.len == 4'(MAX_LEN)) begin
            w_blk[MAX_LEN] = 8'h80;
        end
        w_blk[56] = {1'b0, i_job.len, 3'b000};
    end

    // Round function and message word pick
    always_comb begin
        case (r_i[5:4])
            2'd0: begin w_f = (r_b & r_c) | (~r_b & r_d); w_g = r_i[3:0]; end
            2'd1: begin w_f = (r_d & r_b) | (~r_d & r_c); w_g = 4'(5 * r_i + 1); end
            2'd2: begin w_f = r_b ^ r_c ^ r_d; w_g = 4'(3 * r_i + 5); end
            default: begin w_f = r_c ^ (r_b | ~r_d); w_g = 4'(7 * r_i); end
        endcase
        w_s   = md5_s(r_i);
        w_sum = r_a + w_f + md5_k(r_i) + r_w[w_g];
        w_rot = (w_sum << w_s) | (w_sum >> (6'd32 - {1'b0, w_s}));
        w_nb  = r_b + w_rot;
        w_sa  = 32'h67452301 + r_d;
        w_sb  = 32'hefcdab89 + w_nb;
        w_sc  = 32'h98badcfe + r_b;
        w_sd  = 32'h10325476 + r_c;
    end

    // Digest bytes, byte 0 first
    assign o_shard = r_dg[127:120];
    assign o_up    = r_dg[119:56];
    assign o_lo    = r_dg[55:0];
    assign o_len   = r_len;
    assign o_pw    = r_pw;

    function automatic logic [31:0] bswap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Run 64 rounds, then hold the record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        for (int j = 0; j < 16; j++) begin
                            r_w[j] <= {w_blk[4*j+3], w_blk[4*j+2], w_blk[4*j+1], w_blk[4*j]};
                        end
                        r_a <= 32'h67452301;
                        r_b <= 32'hefcdab89;
                        r_c <= 32'h98badcfe;
                        r_d <= 32'h10325476;
                        r_i <= 6'd0;
                        r_len <= i_job.len;
                        r_pw  <= i_job.pw;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_a <= r_d;
                    r_d <= r_c;
                    r_c <= r_b;
                    r_b <= w_nb;
                    r_i <= r_i + 6'd1;
                    if (r_i == 6'd63) begin
                        r_dg <= {bswap(w_sa), bswap(w_sb), bswap(w_sc), bswap(w_sd)};
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/mask_candidate_md5_record.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mask_candidate_md5_record
// Decodes a candidate index into a password from the charset table and
// returns its MD5 record.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tuser opcode; tdata table_position, table_char, candidate_index
// m_axis    out  tdata shard, digest_upper, digest_lower, pw_len, password_bytes
// cfg       in   index 0 charset_size, 1 password_length
//
// For each character a hash item runs through the decoder's 64 division
// steps plus a table read and write, for up to eight characters; the MD5
// core then runs 64 rounds and hands the record over. Decoder and core
// overlap through a two-entry queue. Load items write the table as accepted.
// Reset clears control only; the charset table is unset until written.
// ----------------------------------------------------------------------------
module mask_candidate_md5_record
    import mcm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [0:0]   s_axis_tuser,   // opcode
    input  wire logic [79:0]  s_axis_tdata,   // table_position, table_char, candidate_index
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [199:0]      m_axis_tdata,   // shard, digest_upper, digest_lower,
                                              // pw_len, password_bytes, zero fill
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data
);

    logic [7:0]       r_radix;
    logic [LEN_W-1:0] r_len;
    t_job             w_fjob, w_qjob;
    logic             w_fv, w_fr, w_qv, w_qr;
    logic [7:0]       w_shard;
    logic [63:0]      w_up, w_pw;
    logic [55:0]      w_lo;
    logic [LEN_W-1:0] w_len;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= 8'd1;
            r_len   <= 4'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CHARSET_SIZE: r_radix <= i_cfg_data;
                REG_PW_LENGTH:    r_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    mcm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_opcode(s_axis_tuser[0]), .i_pos(s_axis_tdata[7:0]),
        .i_char(s_axis_tdata[15:8]), .i_index(s_axis_tdata[79:16]),
        .i_radix(r_radix), .i_len(r_len),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fjob)
    );

    mcm_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_data(w_fjob),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qjob)
    );

    mcm_md5 u_md5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_job(w_qjob),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_shard(w_shard), .o_up(w_up), .o_lo(w_lo), .o_len(w_len), .o_pw(w_pw)
    );

    assign m_axis_tdata = {4'd0, w_pw, w_len, w_lo, w_up, w_shard};

endmodule
`default_nettype wire

>>> src/mcm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcm_checker
// Port-level checks on the record stream, bound to the top level.
// ----------------------------------------------------------------------------
module mcm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [199:0] m_axis_tdata
);

    // A stalled record holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("record changed while stalled");

    // Length lies in one to eight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[131:128] != 4'd0 && m_axis_tdata[131:128] <= 4'd8)
        else $error("length out of range");

    // For length one, the bytes past the first are zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[131:128] == 4'd1 |-> m_axis_tdata[187:132] == 56'd0)
        else $error("padding not zero");

    // No record follows one taken in the very next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("record repeated");

endmodule

bind mask_candidate_md5_record mcm_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Loads the charset table and streams load and hash words into the mask
// candidate block under several radix and length settings. A scoreboard
// decodes each hash word, computes MD5 itself and compares every record.
// ----------------------------------------------------------------------------
module testbench;
    import mcm_pkg::*;

    typedef struct {
        logic [7:0]  shard;
        logic [63:0] dig_up;
        logic [55:0] dig_lo;
        logic [3:0]  len;
        logic [63:0] pw;
    } md5_rec_t;

    // Candidate decoder and MD5 digest predictor with its own record queue
    class md5_scoreboard;
        logic [7:0]  charset [256];
        logic [7:0]  radix_reg;
        logic [3:0]  len_reg;
        md5_rec_t    pending_recs [$];
        int          errors;

        function new();
            radix_reg = 8'd1;
            len_reg   = 4'd1;
            errors    = 0;
        endfunction

        function void note_config(logic [0:0] idx, logic [7:0] data);
            if (idx == REG_CHARSET_SIZE) radix_reg = data;
            else len_reg = data[3:0];
        endfunction

        function logic [31:0] sine_const(int i);
            logic [31:0] k [64];
            k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                  32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                  32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                  32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                  32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                  32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                  32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                  32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                  32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                  32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                  32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                  32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                  32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                  32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                  32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                  32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
            return k[i];
        endfunction

        // One-block MD5 of a short password, digest bytes in order
        function void md5_digest(logic [7:0] pwd [8], int n, output logic [7:0] dg [16]);
            logic [7:0]  blk [64];
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t, s;
            int          rot [16];
            int          i, g, r;
            rot = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            for (i = 0; i < 64; i++) blk[i] = 8'h00;
            for (i = 0; i < n; i++) blk[i] = pwd[i];
            blk[n]  = 8'h80;
            blk[56] = 8'(n * 8);
            for (i = 0; i < 16; i++)
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
            for (i = 0; i < 64; i++) begin
                r = i / 16;
                case (r)
                    0: begin f = (b & c) | (~b & d); g = i; end
                    1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
                    2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
                    default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
                endcase
                s = a + f + sine_const(i) + w[g];
                t = d;
                d = c;
                c = b;
                b = b + ((s << rot[r * 4 + i % 4]) | (s >> (32 - rot[r * 4 + i % 4])));
                a = t;
            end
            a = a + 32'h67452301; b = b + 32'hefcdab89;
            c = c + 32'h98badcfe; d = d + 32'h10325476;
            for (i = 0; i < 4; i++) begin
                dg[i]      = a[8*i +: 8];
                dg[4 + i]  = b[8*i +: 8];
                dg[8 + i]  = c[8*i +: 8];
                dg[12 + i] = d[8*i +: 8];
            end
        endfunction

        // Apply a load word, or decode and hash a candidate index
        function void note_input(logic op, logic [7:0] pos, logic [7:0] ch, logic [63:0] idx);
            logic [63:0] x, radix, digit;
            logic [7:0]  pwd [8];
            logic [7:0]  dg [16];
            md5_rec_t    rec;
            int          n, i;
            if (op == OP_LOAD) begin
                charset[pos] = ch;
                return;
            end
            radix = (radix_reg == 0) ? 64'd1 : {56'd0, radix_reg};
            n = (len_reg == 0) ? 1 : (len_reg > MAX_LEN) ? MAX_LEN : int'(len_reg);
            for (i = 0; i < 8; i++) pwd[i] = 8'h00;
            x = idx;
            for (i = n; i > 0; i--) begin
                digit = x % radix;
                x = x / radix;
                pwd[i - 1] = charset[digit[7:0]];
            end
            md5_digest(pwd, n, dg);
            rec.shard = dg[0];
            for (i = 1; i <= 8; i++) rec.dig_up = {rec.dig_up[55:0], dg[i]};
            for (i = 9; i <= 15; i++) rec.dig_lo = {rec.dig_lo[47:0], dg[i]};
            rec.len = 4'(n);
            for (i = 0; i < 8; i++) rec.pw = {rec.pw[55:0], pwd[i]};
            pending_recs.push_back(rec);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [199:0] word);
            md5_rec_t want;
            if (pending_recs.size() == 0) begin
                report("unexpected record", word[63:0], 64'd0);
                return;
            end
            want = pending_recs.pop_front();
            if (word[7:0] != want.shard)      report("shard", word[7:0], want.shard);
            if (word[71:8] != want.dig_up)    report("digest_upper", word[71:8], want.dig_up);
            if (word[127:72] != want.dig_lo)  report("digest_lower", word[127:72], want.dig_lo);
            if (word[131:128] != want.len)    report("pw_len", word[131:128], want.len);
            if (word[195:132] != want.pw)     report("password", word[195:132], want.pw);
            if (word[199:196] != 4'd0)        report("fill", word[199:196], 0);
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [0:0]   s_axis_tuser;   // opcode
    logic [79:0]  s_axis_tdata;   // table_position, table_char, candidate_index
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;   // shard, digest_upper, digest_lower, pw_len, password
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [0:0]   i_cfg_index;
    logic [7:0]   i_cfg_data;

    md5_scoreboard sb;
    bit            src_burst;
    bit            sink_burst;

    mask_candidate_md5_record u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the whole run
    initial begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Send one word; called and left at a falling edge
    task send_word(logic op, logic [7:0] pos, logic [7:0] ch, logic [63:0] idx);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {idx, ch, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, pos, ch, idx);
        @(negedge i_clk);
    endtask

    task send_hash(logic [63:0] idx);
        send_word(OP_HASH, 8'($urandom), 8'($urandom), idx);
    endtask

    // Hold until every record is back, then let a late load settle
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_recs.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task write_reg(logic [0:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: draw a stall per word, accept and check
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
            @(negedge i_clk);
        end
    end

    // Stimulus
    initial begin
        logic [7:0]  radix_set [8];
        logic [7:0]  len_set [8];
        logic [63:0] keyspace;
        int          p, n, k;
        sb = new();
        radix_set = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd16, 8'd255, 8'd3, 8'd62};
        len_set   = '{8'd1, 8'd8, 8'd0, 8'd15, 8'd4, 8'd1, 8'hf9, 8'd6};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= OP_LOAD;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_CHARSET_SIZE;
        i_cfg_data    <= '0;
        src_burst     = 1'b0;
        sink_burst    = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the whole table so no entry is read before it is written
        src_burst = 1'b1;
        for (p = 0; p < 256; p++) send_word(OP_LOAD, 8'(p), 8'($urandom), 64'($urandom));
        src_burst = 1'b0;

        // Reset settings first, then each radix and length pair
        for (p = 0; p < 8; p++) begin
            if (p > 0) begin
                wait_idle();
                write_reg(REG_CHARSET_SIZE, radix_set[p]);
                write_reg(REG_PW_LENGTH, len_set[p]);
            end
            src_burst  = (p % 3 == 1);
            sink_burst = (p % 4 == 2);
            // Edge indices: zero, all ones, last of the keyspace and just past it
            n = (len_set[p][3:0] == 0) ? 1 : (len_set[p][3:0] > 8) ? 8 : len_set[p][3:0];
            keyspace = 64'd1;
            for (k = 0; k < n; k++)
                keyspace = keyspace * ((radix_set[p] == 0) ? 64'd1 : 64'(radix_set[p]));
            if (p == 0) keyspace = 64'd1;
            send_hash(64'd0);
            send_hash('1);
            send_hash(keyspace - 64'd1);
            send_hash(keyspace);
            send_word(OP_LOAD, 8'd255, 8'($urandom), '1);
            for (k = 0; k < 26; k++) begin
                if ($urandom_range(0, 9) < 2)
                    send_word(OP_LOAD, 8'($urandom), 8'($urandom), {$urandom, $urandom});
                else if ($urandom_range(0, 1) == 0)
                    send_hash(64'($urandom_range(0, 1000)) % keyspace);
                else
                    send_hash({$urandom, $urandom});
            end
        end
        src_burst = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending_recs.size() != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_recs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> mask_candidate_md5_record.f
src/mcm_pkg.sv
src/mcm_front.sv
src/mcm_fifo.sv
src/mcm_md5.sv
src/mask_candidate_md5_record.sv
src/mcm_checker.sv
test/testbench.sv
